/* hw/rtl/tkc_pkg.sv */
// Shared types, character codes and classification functions for the C token classifier.
package tkc_pkg;

    typedef logic [7:0] byte_t;

    // Token classes as carried on the result channel
    typedef enum logic [2:0] {
        KIND_KEYWORD   = 3'd0,
        KIND_INTEGER   = 3'd1,
        KIND_REAL      = 3'd2,
        KIND_IDENT     = 3'd3,
        KIND_NOT_IDENT = 3'd4,
        KIND_OPERATOR  = 3'd5,
        KIND_SEPARATOR = 3'd6,
        KIND_END       = 3'd7
    } kind_t;

    localparam int TEXT_CHARS = 8;
    localparam int TEXT_W     = 8 * TEXT_CHARS;
    localparam int START_W    = 12;
    localparam int LEN_W      = 8;
    localparam int KW_COUNT   = 22;

    // Result queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // One result transaction
    typedef struct packed {
        kind_t               kind;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    length;
        logic [TEXT_W-1:0]   text;
        logic                eot;
    } result_t;

    // Push strobes from the lexer into the result queue
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    localparam byte_t CH_SPACE  = " ";
    localparam byte_t CH_PLUS   = "+";
    localparam byte_t CH_MINUS  = "-";
    localparam byte_t CH_STAR   = "*";
    localparam byte_t CH_SLASH  = "/";
    localparam byte_t CH_COMMA  = ",";
    localparam byte_t CH_SEMI   = ";";
    localparam byte_t CH_GT     = ">";
    localparam byte_t CH_LT     = "<";
    localparam byte_t CH_EQ     = "=";
    localparam byte_t CH_LPAREN = "(";
    localparam byte_t CH_RPAREN = ")";
    localparam byte_t CH_LBRACK = "[";
    localparam byte_t CH_RBRACK = "]";
    localparam byte_t CH_LBRACE = "{";
    localparam byte_t CH_RBRACE = "}";
    localparam byte_t CH_DOT    = ".";
    localparam byte_t CH_ZERO   = "0";
    localparam byte_t CH_NINE   = "9";

    // Keywords written back to front: a string literal puts its last character in
    // the low byte, while word text keeps its first character in the low byte.
    localparam logic [TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        "fi", "esle", "elihw", "od", "kaerb", "eunitnoc", "tni", "elbuod",
        "taolf", "nruter", "rahc", "esac", "foezis", "gnol", "trohs", "fedepyt",
        "hctiws", "dengisnu", "diov", "citats", "tcurts", "otog"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6,
        4'd5, 4'd6, 4'd4, 4'd4, 4'd6, 4'd4, 4'd5, 4'd7,
        4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4
    };

    function automatic logic is_oper(input byte_t c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_GT || c == CH_LT || c == CH_EQ;
    endfunction

    function automatic logic is_sep(input byte_t c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
               c == CH_RPAREN || c == CH_COMMA || c == CH_SEMI;
    endfunction

    function automatic logic is_delim(input byte_t c);
        return is_oper(c) || is_sep(c) || c == CH_SPACE ||
               c == CH_LBRACK || c == CH_RBRACK;
    endfunction

    function automatic logic is_digit(input byte_t c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Parallel compare against every keyword; zero padding makes text compare exact
    function automatic logic kw_match(input logic [TEXT_W-1:0] text,
                                      input logic [LEN_W-1:0]  len);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (len == LEN_W'(KW_LEN[k]) && text == KW_TEXT[k]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

/* hw/rtl/tkc_lexer.sv */
// Input register, word state and per-character token classification.
module tkc_lexer import tkc_pkg::*; #(
    parameter int POSITION_BITS = 12
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_take,
    input  byte_t   in_char,
    input  logic    in_final,
    output logic    busy,
    output push_t   push,
    output result_t res0,
    output result_t res1
);

    // Input register
    logic  stage_valid_reg;
    byte_t stage_char_reg;
    logic  stage_final_reg;

    // Word state
    byte_t                    chars_reg [TEXT_CHARS];
    byte_t                    chars_next [TEXT_CHARS];
    logic [LEN_W-1:0]         len_reg, len_next;
    logic                     digits_reg, digits_next;
    logic                     dot_reg, dot_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    byte_t                    chars_upd [TEXT_CHARS];
    logic [LEN_W-1:0]         len_upd;
    logic                     digits_upd;
    logic                     dot_upd;
    logic [POSITION_BITS-1:0] begin_upd;
    logic [TEXT_W-1:0]        text_upd;

    logic    delim, delim_emits, word_close, fin;
    kind_t   word_kind;
    result_t word_res, delim_res, end_res;

    assign busy = stage_valid_reg;
    assign fin  = stage_final_reg;

    // Capture the accepted character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= in_take;
        end
        if (in_take) begin
            stage_char_reg  <= in_char;
            stage_final_reg <= in_final;
        end
    end

    // Word as it stands after this character
    always_comb begin
        delim      = is_delim(stage_char_reg);
        chars_upd  = chars_reg;
        if (!delim && len_reg < LEN_W'(TEXT_CHARS)) begin
            chars_upd[len_reg[$clog2(TEXT_CHARS)-1:0]] = stage_char_reg;
        end
        len_upd    = (!delim && len_reg != '1) ? len_reg + 1'b1 : len_reg;
        digits_upd = digits_reg &
                     (delim | is_digit(stage_char_reg) | stage_char_reg == CH_DOT);
        dot_upd    = dot_reg | (!delim && stage_char_reg == CH_DOT);
        begin_upd  = (!delim && len_reg == '0) ? pos_reg : begin_reg;
        for (int i = 0; i < TEXT_CHARS; i++) begin
            text_upd[8*i +: 8] = chars_upd[i];
        end
    end

    // Classification, first match wins
    always_comb begin
        if (kw_match(text_upd, len_upd)) begin
            word_kind = KIND_KEYWORD;
        end else if (digits_upd && !dot_upd) begin
            word_kind = KIND_INTEGER;
        end else if (digits_upd) begin
            word_kind = KIND_REAL;
        end else if (is_digit(chars_upd[0])) begin
            word_kind = KIND_NOT_IDENT;
        end else begin
            word_kind = KIND_IDENT;
        end
    end

    // Candidate results and their ordering
    always_comb begin
        word_close  = (delim || fin) && len_upd != '0;
        delim_emits = delim && (is_oper(stage_char_reg) || is_sep(stage_char_reg));

        word_res = '{kind: word_kind, start: START_W'(begin_upd), length: len_upd,
                     text: text_upd, eot: 1'b0};
        delim_res = '{kind: is_oper(stage_char_reg) ? KIND_OPERATOR : KIND_SEPARATOR,
                      start: START_W'(pos_reg), length: LEN_W'(1),
                      text: TEXT_W'(stage_char_reg), eot: 1'b0};
        end_res = '{kind: KIND_END, start: START_W'(pos_reg), length: '0,
                    text: '0, eot: 1'b0};

        res1        = delim_res;
        push.second = 1'b0;
        if (word_close) begin
            res0        = word_res;
            push.second = stage_valid_reg && delim_emits;
        end else if (delim_emits) begin
            res0 = delim_res;
        end else begin
            res0 = end_res;
        end
        push.first = stage_valid_reg && (word_close || delim_emits || fin);

        // Final character marks the last result it causes
        if (fin) begin
            if (push.second) begin
                res1.eot = 1'b1;
            end else begin
                res0.eot = 1'b1;
            end
        end
    end

    // Next word state: cleared on close or end of text
    always_comb begin
        chars_next  = chars_reg;
        len_next    = len_reg;
        digits_next = digits_reg;
        dot_next    = dot_reg;
        begin_next  = begin_reg;
        pos_next    = pos_reg;
        if (stage_valid_reg) begin
            if (word_close || fin) begin
                for (int i = 0; i < TEXT_CHARS; i++) begin
                    chars_next[i] = '0;
                end
                len_next    = '0;
                digits_next = 1'b1;
                dot_next    = 1'b0;
                begin_next  = '0;
            end else begin
                chars_next  = chars_upd;
                len_next    = len_upd;
                digits_next = digits_upd;
                dot_next    = dot_upd;
                begin_next  = begin_upd;
            end
            pos_next = fin ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TEXT_CHARS; i++) begin
                chars_reg[i] <= '0;
            end
            len_reg    <= '0;
            digits_reg <= 1'b1;
            dot_reg    <= 1'b0;
            begin_reg  <= '0;
            pos_reg    <= '0;
        end else begin
            chars_reg  <= chars_next;
            len_reg    <= len_next;
            digits_reg <= digits_next;
            dot_reg    <= dot_next;
            begin_reg  <= begin_next;
            pos_reg    <= pos_next;
        end
    end

    // A final character always produces a result carrying the end mark
    a_final_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && stage_final_reg) |-> (push.first && (res0.eot || res1.eot)))
        else $error("final character produced no end-marked result");

    // Position restarts after the end of a text
    a_pos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && stage_final_reg) |=> (pos_reg == '0 && len_reg == '0))
        else $error("word state not cleared after final character");

endmodule

/* hw/rtl/tkc_result_fifo.sv */
// Result queue: takes up to two transactions per cycle, delivers one.
module tkc_result_fifo import tkc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  push_t              push,
    input  result_t            res0,
    input  result_t            res1,
    input  logic               pop,
    output result_t            head,
    output logic [FIFO_CW-1:0] count
);

    result_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_AW-1:0] wr_ptr_plus1;
    logic [1:0]         push_cnt;

    assign count        = count_reg;
    assign head         = mem[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Pointer and occupancy update
    always_comb begin
        push_cnt    = {1'b0, push.first} + {1'b0, push.second};
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes, second result lands behind the first
    always_ff @(posedge aclk) begin
        if (push.first) begin
            mem[wr_ptr_reg] <= res0;
        end
        if (push.second) begin
            mem[wr_ptr_plus1] <= res1;
        end
    end

    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.second |-> push.first)
        else $error("second result pushed without first");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(count_reg) + 32'(push_cnt)) <= (FIFO_DEPTH + 32'(pop)))
        else $error("result queue overflow");

endmodule

/* hw/rtl/c_token_classifier.sv */
// Top level of the C token classifier: character stream in, token stream out.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid / s_ready | s_char_code[7:0], s_final_char
//  m_      | out | m_valid / m_ready | m_token_kind[2:0], m_token_start[11:0],
//          |     |                   | m_token_length[7:0], m_token_text[63:0],
//          |     |                   | m_end_of_text
//
// One character is accepted per cycle while s_ready is high; a character yields zero to
// two tokens, and the output port delivers one token per cycle, so a word closed by an
// operator or separator adds one extra token, absorbed by the eight-entry result queue.
// A character passes through the input register, then the result queue.
// s_ready depends only on registers: it drops once queued plus in-flight results
// could exceed the queue, so a stalled m_ready throttles the input.
// aresetn (synchronous, active low) empties the queue and clears the word state.
module c_token_classifier import tkc_pkg::*; #(
    parameter int POSITION_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_final_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_token_kind,
    output logic [11:0] m_token_start,
    output logic [7:0]  m_token_length,
    output logic [63:0] m_token_text,
    output logic        m_end_of_text
);

    logic               in_take;
    logic               busy;
    push_t              push;
    result_t            res0, res1, head;
    logic [FIFO_CW-1:0] count;
    logic               pop;

    // Room for this cycle's and the in-flight character's results
    assign s_ready = (FIFO_CW'(count) + (busy ? FIFO_CW'(2) : FIFO_CW'(0)))
                     <= FIFO_CW'(FIFO_DEPTH - 2);
    assign in_take = s_valid && s_ready;

    tkc_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (in_take),
        .in_char (s_char_code),
        .in_final(s_final_char),
        .busy    (busy),
        .push    (push),
        .res0    (res0),
        .res1    (res1)
    );

    tkc_result_fifo u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .res0   (res0),
        .res1   (res1),
        .pop    (pop),
        .head   (head),
        .count  (count)
    );

    // Result channel straight from the queue head
    assign m_valid        = count != '0;
    assign pop            = m_valid && m_ready;
    assign m_token_kind   = head.kind;
    assign m_token_start  = head.start;
    assign m_token_length = head.length;
    assign m_token_text   = head.text;
    assign m_end_of_text  = head.eot;

    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> (busy && count <= FIFO_CW'(FIFO_DEPTH - 2)))
        else $error("character accepted without queue room");

endmodule

/* verif/tkc_token_checker.sv */
// Token checker: predicts the token stream from accepted characters and compares results.
module tkc_token_checker import tkc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_final_char,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_token_kind,
    input  logic [11:0] m_token_start,
    input  logic [7:0]  m_token_length,
    input  logic [63:0] m_token_text,
    input  logic        m_end_of_text,
    output int          fail_count,
    output int          tokens_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // What a character does to the word being built
    typedef enum logic [1:0] {
        CC_WORD,
        CC_SILENT,
        CC_OPER,
        CC_SEP
    } char_class_t;

    string kw_words [KW_COUNT] = '{
        "if", "else", "while", "do", "break", "continue", "int", "double",
        "float", "return", "char", "case", "sizeof", "long", "short", "typedef",
        "switch", "unsigned", "void", "static", "struct", "goto"
    };

    // Word under construction and stream position
    byte_t              word_chars [TEXT_CHARS];
    logic [LEN_W-1:0]   word_len;
    logic               word_digits;
    logic               word_dot;
    logic [START_W-1:0] word_begin;
    logic [START_W-1:0] char_pos;

    // Tokens predicted but not yet seen on the result channel
    result_t expected_tokens [$];

    function automatic char_class_t classify(input byte_t c);
        case (c)
            "+", "-", "*", "/", ">", "<", "=": return CC_OPER;
            "(", ")", "{", "}", ",", ";":      return CC_SEP;
            " ", "[", "]":                     return CC_SILENT;
            default:                           return CC_WORD;
        endcase
    endfunction

    function automatic logic is_numeral(input byte_t c);
        return c >= "0" && c <= "9";
    endfunction

    // Whole-word keyword match; length check keeps trailing NULs from matching
    function automatic logic word_is_keyword();
        logic same;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (int'(word_len) == kw_words[k].len()) begin
                same = 1'b1;
                for (int i = 0; i < kw_words[k].len(); i++) begin
                    if (word_chars[i] != kw_words[k][i]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic kind_t word_kind();
        if (word_is_keyword()) return KIND_KEYWORD;
        if (word_digits && !word_dot) return KIND_INTEGER;
        if (word_digits) return KIND_REAL;
        if (is_numeral(word_chars[0])) return KIND_NOT_IDENT;
        return KIND_IDENT;
    endfunction

    function automatic logic [TEXT_W-1:0] word_text();
        logic [TEXT_W-1:0] t;
        for (int i = 0; i < TEXT_CHARS; i++) begin
            t[8*i +: 8] = word_chars[i];
        end
        return t;
    endfunction

    task automatic clear_word();
        for (int i = 0; i < TEXT_CHARS; i++) begin
            word_chars[i] = '0;
        end
        word_len    = '0;
        word_digits = 1'b1;
        word_dot    = 1'b0;
        word_begin  = '0;
    endtask

    // Advance the lexer by one character and queue the tokens it closes
    task automatic lex_char(input byte_t c, input logic fin);
        result_t            toks [2];
        int                 n;
        char_class_t        cc;
        logic [START_W-1:0] here;
        n    = 0;
        cc   = classify(c);
        here = char_pos;

        if (cc == CC_WORD) begin
            if (word_len == 0) word_begin = here;
            if (word_len < TEXT_CHARS) word_chars[word_len] = c;
            if (!is_numeral(c) && c != ".") word_digits = 1'b0;
            if (c == ".") word_dot = 1'b1;
            if (word_len != 8'hFF) word_len++;
        end

        // Delimiter or end of text closes a pending word
        if ((cc != CC_WORD || fin) && word_len != 0) begin
            toks[n].kind   = word_kind();
            toks[n].start  = word_begin;
            toks[n].length = word_len;
            toks[n].text   = word_text();
            toks[n].eot    = 1'b0;
            n++;
            clear_word();
        end

        if (cc == CC_OPER || cc == CC_SEP) begin
            toks[n].kind   = (cc == CC_OPER) ? KIND_OPERATOR : KIND_SEPARATOR;
            toks[n].start  = here;
            toks[n].length = 8'd1;
            toks[n].text   = TEXT_W'(c);
            toks[n].eot    = 1'b0;
            n++;
        end

        // Final character: flag the last token, or emit a bare end marker
        if (fin) begin
            if (n == 0) begin
                toks[0].kind   = KIND_END;
                toks[0].start  = here;
                toks[0].length = '0;
                toks[0].text   = '0;
                n = 1;
            end
            toks[n-1].eot = 1'b1;
            clear_word();
            char_pos = '0;
        end else begin
            char_pos = here + 1'b1;
        end

        for (int i = 0; i < n; i++) begin
            expected_tokens.push_back(toks[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [TEXT_W-1:0] want,
                               input logic [TEXT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Retire the result side first so an input on the same edge cannot mask it
    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            clear_word();
            char_pos = '0;
            expected_tokens.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token with none expected: kind %0d start %0d text %0h",
                           m_token_kind, m_token_start, m_token_text);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, m_token_kind);
                    check_field("token_start", want.start, m_token_start);
                    check_field("token_length", want.length, m_token_length);
                    check_field("token_text", want.text, m_token_text);
                    check_field("end_of_text", want.eot, m_end_of_text);
                end
            end
            if (s_valid && s_ready) begin
                lex_char(s_char_code, s_final_char);
            end
        end
        tokens_pending = expected_tokens.size();
    end

endmodule

/* verif/tb_c_token_classifier.sv */
// Testbench top for the C token classifier: character stimulus, result back-pressure, verdict.
module tb_c_token_classifier;
    timeunit 1ns;
    timeprecision 1ps;
    import tkc_pkg::*;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_CHOKED
    } rx_mode_t;

    typedef enum int {
        W_KEYWORD,
        W_NEAR_KW,
        W_INTEGER,
        W_REAL,
        W_IDENT,
        W_NOT_IDENT,
        W_RAW
    } word_shape_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic [7:0]  s_char_code  = '0;
    logic        s_final_char = 1'b0;
    logic        m_ready      = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_token_kind;
    logic [11:0] m_token_start;
    logic [7:0]  m_token_length;
    logic [63:0] m_token_text;
    logic        m_end_of_text;
    int          fail_count;
    int          tokens_pending;

    // Source text waiting to be streamed in
    byte_t text_q [$];
    int    burst_left = 0;
    int    chars_sent = 0;
    string delim_set  = " +-*/,;><=()[]{}";
    string kw_pool [KW_COUNT] = '{
        "if", "else", "while", "do", "break", "continue", "int", "double",
        "float", "return", "char", "case", "sizeof", "long", "short", "typedef",
        "switch", "unsigned", "void", "static", "struct", "goto"
    };

    c_token_classifier u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_final_char   (s_final_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_token_text   (m_token_text),
        .m_end_of_text  (m_end_of_text)
    );

    tkc_token_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_final_char   (s_final_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_token_text   (m_token_text),
        .m_end_of_text  (m_end_of_text),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic byte_t pick_digit();
        return byte_t'("0" + $urandom_range(0, 9));
    endfunction

    function automatic byte_t pick_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return byte_t'("a" + r);
        if (r < 52) return byte_t'("A" + r - 26);
        return "_";
    endfunction

    // Identifier tail: letters, digits, underscore and the odd dot
    function automatic byte_t pick_name_char();
        int r;
        r = $urandom_range(0, 11);
        if (r < 7) return pick_alpha();
        if (r < 11) return pick_digit();
        return ".";
    endfunction

    task automatic add_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic add_delims();
        repeat ($urandom_range(1, 2)) begin
            text_q.push_back(delim_set[$urandom_range(0, delim_set.len() - 1)]);
        end
    endtask

    task automatic add_word(input word_shape_t shape);
        string kw;
        case (shape)
            W_KEYWORD: begin
                add_string(kw_pool[$urandom_range(0, KW_COUNT - 1)]);
            end
            // Keyword with an extra char, one char short, or a trailing NUL
            W_NEAR_KW: begin
                kw = kw_pool[$urandom_range(0, KW_COUNT - 1)];
                case ($urandom_range(0, 2))
                    0: begin
                        add_string(kw);
                        text_q.push_back(pick_alpha());
                    end
                    1: begin
                        add_string(kw.substr(0, kw.len() - 2));
                    end
                    default: begin
                        add_string(kw);
                        text_q.push_back(8'h00);
                    end
                endcase
            end
            W_INTEGER: begin
                repeat ($urandom_range(1, 6)) text_q.push_back(pick_digit());
            end
            W_REAL: begin
                repeat ($urandom_range(0, 3)) text_q.push_back(pick_digit());
                text_q.push_back(".");
                repeat ($urandom_range(0, 3)) begin
                    text_q.push_back(($urandom_range(0, 3) == 0) ? byte_t'(".") : pick_digit());
                end
            end
            W_IDENT: begin
                text_q.push_back(pick_alpha());
                repeat ($urandom_range(0, 10)) text_q.push_back(pick_name_char());
            end
            W_NOT_IDENT: begin
                text_q.push_back(pick_digit());
                text_q.push_back(pick_alpha());
                repeat ($urandom_range(0, 5)) text_q.push_back(pick_name_char());
            end
            default: begin
                repeat ($urandom_range(1, 10)) text_q.push_back(byte_t'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Well-formed snippet: words separated by delimiters, sometimes ending on a word
    task automatic add_program(input int words);
        if ($urandom_range(0, 3) == 0) add_delims();
        repeat (words) begin
            add_word(word_shape_t'($urandom_range(0, W_RAW)));
            add_delims();
        end
        if ($urandom_range(0, 1) == 0) void'(text_q.pop_back());
    endtask

    // One character transaction; sender idles between bursts of random length
    task automatic send_char(input byte_t c, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
        s_valid      <= 1'b1;
        s_char_code  <= c;
        s_final_char <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
        chars_sent++;
    endtask

    // Stream the queued text, marking its last character final
    task automatic send_text();
        foreach (text_q[i]) begin
            send_char(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    // Result side: random stall modes, plus one long hold-off to fill the queue
    initial begin : receiver
        rx_mode_t mode;
        int       span;
        int       cycle;
        span  = 0;
        cycle = 0;
        mode  = RX_OPEN;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            cycle++;
            if (span == 0) begin
                mode = rx_mode_t'($urandom_range(0, RX_CHOKED));
                span = $urandom_range(16, 64);
            end
            span--;
            if (cycle >= 300 && cycle < 450) begin
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:  m_ready <= 1'b1;
                    RX_COIN:  m_ready <= ($urandom_range(0, 1) == 1);
                    default:  m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic long_done;
        long_done = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every token class, end marker, odd bytes
        add_string("int a1=9z;");
        send_text();
        add_string("3.4+12");
        send_text();
        add_string("[");
        send_text();
        add_string("-");
        send_text();
        text_q = '{8'h00, 8'hFF, 8'h0A};
        send_text();

        // Random: mostly well-formed snippets, some raw byte noise
        while (chars_sent < 100) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 12)) text_q.push_back(byte_t'($urandom_range(0, 255)));
            end else begin
                add_program($urandom_range(1, 8));
            end
            send_text();
        end

        // One long text: a word long enough that its length saturates
        while (text_q.size() < 300) begin
            if (!long_done && text_q.size() > 10) begin
                repeat (270) text_q.push_back(pick_digit());
                add_delims();
                long_done = 1'b1;
            end
            add_word(word_shape_t'($urandom_range(0, W_RAW)));
            add_delims();
        end
        send_text();

        // Position must restart after the final character
        add_program(3);
        send_text();
        s_valid <= 1'b0;

        while (tokens_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tkc_pkg.sv
hw/rtl/tkc_lexer.sv
hw/rtl/tkc_result_fifo.sv
hw/rtl/c_token_classifier.sv
verif/tkc_token_checker.sv
verif/tb_c_token_classifier.sv
